// File: rtl/core/mmpp_pkg.sv
// ----------------------------------------------------------------------------
// mmpp_pkg
// Shared types and fixed constants of the min/max peak pyramid core.
// ----------------------------------------------------------------------------
package mmpp_pkg;

  // Output field width fixed by the result format.
  localparam int LEVEL_BITS = 4;

  // Configuration register widths, reset values and minimums.
  localparam int BASE_BITS  = 17;
  localparam int RATIO_BITS = 5;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = BASE_BITS;

  localparam logic [BASE_BITS-1:0]  BASE_RESET  = 17'd256;
  localparam logic [BASE_BITS-1:0]  BASE_MIN    = 17'd1;
  localparam logic [RATIO_BITS-1:0] RATIO_RESET = 5'd4;
  localparam logic [RATIO_BITS-1:0] RATIO_MIN   = 5'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_BASE_BIN_FRAMES = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_LEVEL_RATIO     = 1'b1;

  // Entries between the level-zero front end and the cascade engine.
  localparam int QUEUE_DEPTH = 4;

  // Per-entry control flags handed from the front end to the back end.
  typedef struct packed {
    logic bin_full;   // level-zero bin reached its threshold
    logic chan_end;   // last sample of the channel, flush follows
  } mmpp_flags_t;

endpackage

// File: rtl/core/mmpp_intf.sv
// ----------------------------------------------------------------------------
// mmpp_in_if / mmpp_out_if
// Valid/ready channels for samples going in and bins coming out.
// ----------------------------------------------------------------------------
interface mmpp_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          end_of_channel;

  modport source (output valid, output sample_value, output end_of_channel, input ready);
  modport sink   (input valid, input sample_value, input end_of_channel, output ready);
endinterface

interface mmpp_out_if #(
  parameter int SAMPLE_BITS    = 16,
  parameter int BIN_INDEX_BITS = 24
);
  logic                                valid;
  logic                                ready;
  logic [mmpp_pkg::LEVEL_BITS-1:0]     level_number;
  logic [BIN_INDEX_BITS-1:0]           bin_number;
  logic signed [SAMPLE_BITS-1:0]       bin_min;
  logic signed [SAMPLE_BITS-1:0]       bin_max;
  logic                                last_of_run;

  modport source (output valid, output level_number, output bin_number, output bin_min,
                  output bin_max, output last_of_run, input ready);
  modport sink   (input valid, input level_number, input bin_number, input bin_min,
                  input bin_max, input last_of_run, output ready);
endinterface

// File: rtl/core/mmpp_front.sv
// ----------------------------------------------------------------------------
// mmpp_front
// Level-zero accumulator: folds one sample per cycle while accepted and
// queues each closed level-zero bin, with its flags, for the cascade engine.
// ----------------------------------------------------------------------------
module mmpp_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic                                chan_end_i,
  input  logic [mmpp_pkg::BASE_BITS-1:0]      base_i,
  output logic                                push_o,
  output mmpp_pkg::mmpp_flags_t               flags_o,
  output logic signed [SAMPLE_BITS-1:0]       mn_o,
  output logic signed [SAMPLE_BITS-1:0]       mx_o
);

  localparam int BB = mmpp_pkg::BASE_BITS;

  logic [BB-1:0]                 fill_r, fill_nxt;
  logic signed [SAMPLE_BITS-1:0] mn_r, mn_nxt;
  logic signed [SAMPLE_BITS-1:0] mx_r, mx_nxt;
  logic [BB:0]                   fill_inc;
  logic [BB-1:0]                 thr;
  logic                          full;

  // A base size of zero behaves as one sample per bin.
  assign thr      = (base_i == '0) ? mmpp_pkg::BASE_MIN : base_i;
  assign fill_inc = {1'b0, fill_r} + {{BB{1'b0}}, 1'b1};
  assign full     = (fill_inc >= {1'b0, thr});

  always_comb begin
    if (fill_r == '0) begin
      mn_nxt = sample_i;
      mx_nxt = sample_i;
    end else begin
      mn_nxt = (sample_i < mn_r) ? sample_i : mn_r;
      mx_nxt = (sample_i > mx_r) ? sample_i : mx_r;
    end
  end

  // Every sample that closes a bin or ends the channel hands a bin onward.
  assign push_o           = accept_i && (full || chan_end_i);
  assign flags_o.bin_full = full;
  assign flags_o.chan_end = chan_end_i;
  assign mn_o             = mn_nxt;
  assign mx_o             = mx_nxt;

  always_comb begin
    fill_nxt = fill_r;
    if (accept_i) begin
      fill_nxt = push_o ? '0 : fill_inc[BB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_i) begin
      mn_r <= mn_nxt;
      mx_r <= mx_nxt;
    end
  end

endmodule

// File: rtl/core/mmpp_queue.sv
// ----------------------------------------------------------------------------
// mmpp_queue
// Small register FIFO between the level-zero front end and the cascade
// engine; the head entry is visible until it is popped.
// ----------------------------------------------------------------------------
module mmpp_queue #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full_o  = (count_r == CW'(DEPTH));
  assign empty_o = (count_r == '0);
  assign data_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  // The front end is held off while the queue is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("queue written while full");

  // The back end only retires an entry that is present.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

endmodule

// File: rtl/core/mmpp_back.sv
// ----------------------------------------------------------------------------
// mmpp_back
// Cascade engine: walks the pyramid levels for one queued level-zero bin,
// one level per cycle unless the output stalls, first merging completed bins
// upward, then at channel end flushing partial bins and clearing all levels.
// ----------------------------------------------------------------------------
module mmpp_back #(
  parameter int MAX_LEVELS     = 12,
  parameter int SAMPLE_BITS    = 16,
  parameter int BIN_INDEX_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [mmpp_pkg::RATIO_BITS-1:0]     ratio_i,
  input  logic                                head_v_i,
  input  mmpp_pkg::mmpp_flags_t               head_flags_i,
  input  logic signed [SAMPLE_BITS-1:0]       head_mn_i,
  input  logic signed [SAMPLE_BITS-1:0]       head_mx_i,
  output logic                                pop_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [mmpp_pkg::LEVEL_BITS-1:0]     out_level_o,
  output logic [BIN_INDEX_BITS-1:0]           out_bin_o,
  output logic signed [SAMPLE_BITS-1:0]       out_min_o,
  output logic signed [SAMPLE_BITS-1:0]       out_max_o,
  output logic                                out_last_o
);

  localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int RB    = mmpp_pkg::RATIO_BITS;
  localparam int LB    = mmpp_pkg::LEVEL_BITS;

  localparam logic [1:0] S_ABSORB = 2'd0;
  localparam logic [1:0] S_FLUSH  = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [LVL_W-1:0]              lvl_r, lvl_nxt;
  logic                          carry_v_r, carry_v_nxt;
  logic signed [SAMPLE_BITS-1:0] carry_mn_r, carry_mn_nxt;
  logic signed [SAMPLE_BITS-1:0] carry_mx_r, carry_mx_nxt;

  logic [RB-1:0]                 fill_r   [MAX_LEVELS];
  logic [RB-1:0]                 fill_nxt [MAX_LEVELS];
  logic [BIN_INDEX_BITS-1:0]     bins_r   [MAX_LEVELS];
  logic [BIN_INDEX_BITS-1:0]     bins_nxt [MAX_LEVELS];
  logic signed [SAMPLE_BITS-1:0] acc_mn_r [MAX_LEVELS];
  logic signed [SAMPLE_BITS-1:0] acc_mx_r [MAX_LEVELS];

  logic                          acc_we;

  // The newest result is parked here until it is known whether it is the
  // last one of its transaction.
  logic                          hold_v_r, hold_v_nxt;
  logic [LB-1:0]                 hold_lvl_r, hold_lvl_nxt;
  logic [BIN_INDEX_BITS-1:0]     hold_bin_r, hold_bin_nxt;
  logic signed [SAMPLE_BITS-1:0] hold_mn_r, hold_mn_nxt;
  logic signed [SAMPLE_BITS-1:0] hold_mx_r, hold_mx_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [LB-1:0]                 out_lvl_r, out_lvl_nxt;
  logic [BIN_INDEX_BITS-1:0]     out_bin_r, out_bin_nxt;
  logic signed [SAMPLE_BITS-1:0] out_mn_r, out_mn_nxt;
  logic signed [SAMPLE_BITS-1:0] out_mx_r, out_mx_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          adv, step;
  logic                          lvl_zero, lvl_top;
  logic [RB-1:0]                 cur_fill;
  logic [BIN_INDEX_BITS-1:0]     cur_bins, new_bins;
  logic signed [SAMPLE_BITS-1:0] cur_mn, cur_mx, f_mn, f_mx;
  logic [RB:0]                   fill_inc;
  logic [RB-1:0]                 ratio_eff;
  logic                          emit, finish_abs, do_clear;
  logic signed [SAMPLE_BITS-1:0] e_mn, e_mx;

  assign adv      = !out_valid_r || out_ready_i;
  assign step     = head_v_i && adv;
  assign lvl_zero = (lvl_r == '0);
  assign lvl_top  = (lvl_r == LVL_W'(MAX_LEVELS - 1));

  assign cur_fill = fill_r[lvl_r];
  assign cur_bins = bins_r[lvl_r];
  assign cur_mn   = acc_mn_r[lvl_r];
  assign cur_mx   = acc_mx_r[lvl_r];
  assign fill_inc = {1'b0, cur_fill} + {{RB{1'b0}}, 1'b1};
  assign ratio_eff = (ratio_i < mmpp_pkg::RATIO_MIN) ? mmpp_pkg::RATIO_MIN : ratio_i;

  // Carried extremes folded into this level's open bin.
  always_comb begin
    if (cur_fill == '0) begin
      f_mn = carry_mn_r;
      f_mx = carry_mx_r;
    end else begin
      f_mn = (carry_mn_r < cur_mn) ? carry_mn_r : cur_mn;
      f_mx = (carry_mx_r > cur_mx) ? carry_mx_r : cur_mx;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    carry_v_nxt   = carry_v_r;
    carry_mn_nxt  = carry_mn_r;
    carry_mx_nxt  = carry_mx_r;
    fill_nxt      = fill_r;
    bins_nxt      = bins_r;
    acc_we        = 1'b0;
    hold_v_nxt    = hold_v_r;
    hold_lvl_nxt  = hold_lvl_r;
    hold_bin_nxt  = hold_bin_r;
    hold_mn_nxt   = hold_mn_r;
    hold_mx_nxt   = hold_mx_r;
    out_valid_nxt = out_valid_r && !out_ready_i;
    out_lvl_nxt   = out_lvl_r;
    out_bin_nxt   = out_bin_r;
    out_mn_nxt    = out_mn_r;
    out_mx_nxt    = out_mx_r;
    out_last_nxt  = out_last_r;
    pop_o         = 1'b0;
    emit          = 1'b0;
    finish_abs    = 1'b0;
    do_clear      = 1'b0;
    new_bins      = cur_bins;
    e_mn          = head_mn_i;
    e_mx          = head_mx_i;

    if (step) begin
      case (state_r)
        S_ABSORB: begin
          if (lvl_zero) begin
            if (head_flags_i.bin_full) begin
              emit = 1'b1;
            end else begin
              finish_abs = 1'b1;
            end
          end else if (fill_inc >= {1'b0, ratio_eff}) begin
            emit = 1'b1;
            e_mn = f_mn;
            e_mx = f_mx;
            fill_nxt[lvl_r] = '0;
          end else begin
            fill_nxt[lvl_r] = fill_inc[RB-1:0];
            acc_we          = 1'b1;
            finish_abs      = 1'b1;
          end
          if (emit) begin
            carry_mn_nxt = e_mn;
            carry_mx_nxt = e_mx;
            if (lvl_top) begin
              finish_abs = 1'b1;
            end else begin
              lvl_nxt = lvl_r + LVL_W'(1);
            end
          end
          if (finish_abs) begin
            lvl_nxt     = '0;
            carry_v_nxt = 1'b0;
            state_nxt   = head_flags_i.chan_end ? S_FLUSH : S_DONE;
          end
        end
        S_FLUSH: begin
          if (lvl_zero) begin
            emit = !head_flags_i.bin_full;
          end else begin
            emit = carry_v_r || (cur_fill != '0);
            e_mn = carry_v_r ? f_mn : cur_mn;
            e_mx = carry_v_r ? f_mx : cur_mx;
          end
          carry_v_nxt  = emit;
          carry_mn_nxt = e_mn;
          carry_mx_nxt = e_mx;
          new_bins     = cur_bins + BIN_INDEX_BITS'(emit);
          // Stops at the first level with at most one bin, or at the top.
          if ((new_bins <= BIN_INDEX_BITS'(1)) || lvl_top) begin
            do_clear  = 1'b1;
            lvl_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            lvl_nxt = lvl_r + LVL_W'(1);
          end
        end
        S_DONE: begin
          out_valid_nxt = 1'b1;
          out_lvl_nxt   = hold_lvl_r;
          out_bin_nxt   = hold_bin_r;
          out_mn_nxt    = hold_mn_r;
          out_mx_nxt    = hold_mx_r;
          out_last_nxt  = 1'b1;
          hold_v_nxt    = 1'b0;
          pop_o         = 1'b1;
          lvl_nxt       = '0;
          state_nxt     = S_ABSORB;
        end
        default: begin
          state_nxt = S_ABSORB;
        end
      endcase

      if (emit) begin
        bins_nxt[lvl_r] = cur_bins + BIN_INDEX_BITS'(1);
        if (hold_v_r) begin
          out_valid_nxt = 1'b1;
          out_lvl_nxt   = hold_lvl_r;
          out_bin_nxt   = hold_bin_r;
          out_mn_nxt    = hold_mn_r;
          out_mx_nxt    = hold_mx_r;
          out_last_nxt  = 1'b0;
        end
        hold_v_nxt   = 1'b1;
        hold_lvl_nxt = LB'(lvl_r);
        hold_bin_nxt = cur_bins;
        hold_mn_nxt  = e_mn;
        hold_mx_nxt  = e_mx;
      end

      // End of channel: every level starts empty for the next channel.
      if (do_clear) begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
          fill_nxt[i] = '0;
          bins_nxt[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ABSORB;
      lvl_r       <= '0;
      carry_v_r   <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        fill_r[i] <= '0;
        bins_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      carry_v_r   <= carry_v_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
      bins_r      <= bins_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_mn_r <= carry_mn_nxt;
    carry_mx_r <= carry_mx_nxt;
    hold_lvl_r <= hold_lvl_nxt;
    hold_bin_r <= hold_bin_nxt;
    hold_mn_r  <= hold_mn_nxt;
    hold_mx_r  <= hold_mx_nxt;
    out_lvl_r  <= out_lvl_nxt;
    out_bin_r  <= out_bin_nxt;
    out_mn_r   <= out_mn_nxt;
    out_mx_r   <= out_mx_nxt;
    out_last_r <= out_last_nxt;
    if (acc_we) begin
      acc_mn_r[lvl_r] <= f_mn;
      acc_mx_r[lvl_r] <= f_mx;
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_level_o = out_lvl_r;
  assign out_bin_o   = out_bin_r;
  assign out_min_o   = out_mn_r;
  assign out_max_o   = out_mx_r;
  assign out_last_o  = out_last_r;

  // Every queued bin produces at least one result, so one is parked at the end.
  a_done_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> hold_v_r)
    else $error("transaction finished without a parked result");

  // Retiring a queue entry always presents its closing result.
  a_done_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_o) |=> (out_valid_r && out_last_r))
    else $error("retired entry did not present a final result");

  // The level walk never runs past the top of the pyramid.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= LVL_W'(MAX_LEVELS - 1))
    else $error("level index beyond the top level");

endmodule

// File: rtl/core/min_max_peak_pyramid_core.sv
// ----------------------------------------------------------------------------
// min_max_peak_pyramid_core
// Multilevel min/max decimation of one channel's samples into a pyramid of
// bins, each bin reported with its level and index as it completes.
// ----------------------------------------------------------------------------
// The core takes one sample per clock while its queue has room. Samples are
// folded into level-zero bins as they arrive; a sample that closes a
// level-zero bin, or that ends the channel, places one entry in a four-deep
// queue. The cascade engine behind the queue visits the pyramid levels for
// that entry and then closes it out: it merges completed bins upward and, at
// the end of a channel, also flushes partial bins upward. Results leave one per
// cycle through an output register while the receiver is ready. While the
// queue has room the sample input stays ready, so with base_bin_frames larger
// than the cascade length and no output back-pressure the sustained rate is
// one sample per cycle; the input stalls only when four queued bins are still
// waiting for the cascade engine. Configuration must be written only while
// the core is idle; the core itself does not enforce this.
module min_max_peak_pyramid_core #(
  parameter int MAX_LEVELS     = 12,
  parameter int SAMPLE_BITS    = 16,
  parameter int BIN_INDEX_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  mmpp_in_if.sink                               in_ch,
  mmpp_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [mmpp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [mmpp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int FLAG_BITS = $bits(mmpp_pkg::mmpp_flags_t);
  localparam int ENTRY_W   = FLAG_BITS + 2 * SAMPLE_BITS;

  logic [mmpp_pkg::BASE_BITS-1:0]  base_r;
  logic [mmpp_pkg::RATIO_BITS-1:0] ratio_r;

  logic                          in_accept;
  logic                          q_push, q_pop, q_full, q_empty;
  mmpp_pkg::mmpp_flags_t         push_flags, head_flags;
  logic signed [SAMPLE_BITS-1:0] push_mn, push_mx, head_mn, head_mx;
  logic [ENTRY_W-1:0]            q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= mmpp_pkg::BASE_RESET;
      ratio_r <= mmpp_pkg::RATIO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mmpp_pkg::CFG_IDX_BASE_BIN_FRAMES: base_r  <= cfg_data;
        mmpp_pkg::CFG_IDX_LEVEL_RATIO:     ratio_r <= cfg_data[mmpp_pkg::RATIO_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = !q_full;
  assign in_accept   = in_ch.valid && !q_full;

  mmpp_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept_i   (in_accept),
    .sample_i   (in_ch.sample_value),
    .chan_end_i (in_ch.end_of_channel),
    .base_i     (base_r),
    .push_o     (q_push),
    .flags_o    (push_flags),
    .mn_o       (push_mn),
    .mx_o       (push_mx)
  );

  assign q_wdata = {push_flags, push_mn, push_mx};

  mmpp_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (mmpp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  assign head_flags = q_rdata[ENTRY_W-1 -: FLAG_BITS];
  assign head_mn    = q_rdata[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
  assign head_mx    = q_rdata[SAMPLE_BITS-1:0];

  mmpp_back #(
    .MAX_LEVELS     (MAX_LEVELS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .BIN_INDEX_BITS (BIN_INDEX_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .ratio_i      (ratio_r),
    .head_v_i     (!q_empty),
    .head_flags_i (head_flags),
    .head_mn_i    (head_mn),
    .head_mx_i    (head_mx),
    .pop_o        (q_pop),
    .out_ready_i  (out_ch.ready),
    .out_valid_o  (out_ch.valid),
    .out_level_o  (out_ch.level_number),
    .out_bin_o    (out_ch.bin_number),
    .out_min_o    (out_ch.bin_min),
    .out_max_o    (out_ch.bin_max),
    .out_last_o   (out_ch.last_of_run)
  );

endmodule

// File: verif/tb_min_max_peak_pyramid_core.sv
// ----------------------------------------------------------------------------
// tb_min_max_peak_pyramid_core
// Self-checking testbench for the min/max peak pyramid core. Samples are
// streamed in channels of random length under a range of bin sizes and merge
// ratios. An in-bench tracker rebuilds the pyramid and checks every bin the
// core reports.
// ----------------------------------------------------------------------------
module tb_min_max_peak_pyramid_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEVELS    = 12;
  localparam int SAMPLE_W      = 16;
  localparam int INDEX_W       = 24;
  localparam int LVL_W         = mmpp_pkg::LEVEL_BITS;
  localparam int BASE_W        = mmpp_pkg::BASE_BITS;
  localparam int RATIO_W       = mmpp_pkg::RATIO_BITS;
  localparam int CIDX_W        = mmpp_pkg::CFG_INDEX_BITS;
  localparam int CDATA_W       = mmpp_pkg::CFG_DATA_BITS;
  // Four queued entries, each up to a full flush of the cascade.
  localparam int SETTLE_CYCLES = 4 * (2 * MAX_LEVELS + 1) + 20;
  localparam int CYCLE_LIMIT   = 1_500_000;

  typedef struct {
    logic [LVL_W-1:0]           level;
    logic [INDEX_W-1:0]         index;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic                       last;
  } bin_t;

  // Rebuilds the pyramid from accepted samples and checks reported bins.
  class pyramid_tracker;
    logic [BASE_W-1:0]          base_frames;
    logic [RATIO_W-1:0]         merge_ratio;
    logic signed [SAMPLE_W-1:0] open_min  [MAX_LEVELS];
    logic signed [SAMPLE_W-1:0] open_max  [MAX_LEVELS];
    logic [BASE_W-1:0]          open_fill [MAX_LEVELS];
    logic [INDEX_W-1:0]         emitted   [MAX_LEVELS];
    bin_t                       step_bins[$];
    bin_t                       pending_bins[$];
    int                         failures;
    int                         bins_checked;
    int                         samples_seen;
    int                         top_level;

    function new();
      base_frames  = mmpp_pkg::BASE_RESET;
      merge_ratio  = mmpp_pkg::RATIO_RESET;
      failures     = 0;
      bins_checked = 0;
      samples_seen = 0;
      top_level    = 0;
      clear_levels();
    endfunction

    function void clear_levels();
      for (int k = 0; k < MAX_LEVELS; k++) begin
        open_min[k]  = '0;
        open_max[k]  = '0;
        open_fill[k] = '0;
        emitted[k]   = '0;
      end
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] value);
      if (idx == mmpp_pkg::CFG_IDX_BASE_BIN_FRAMES)
        base_frames = value;
      else if (idx == mmpp_pkg::CFG_IDX_LEVEL_RATIO)
        merge_ratio = value[RATIO_W-1:0];
    endfunction

    // Fill at which a bin of level k closes; out-of-range settings are clamped.
    function logic [BASE_W-1:0] close_count(int k);
      logic [BASE_W-1:0] limit;
      limit = '0;
      if (k == 0)
        limit = (base_frames == '0) ? mmpp_pkg::BASE_MIN : base_frames;
      else
        limit[RATIO_W-1:0] = (merge_ratio < mmpp_pkg::RATIO_MIN) ? mmpp_pkg::RATIO_MIN :
                             merge_ratio;
      return limit;
    endfunction

    function void fold(int k, logic signed [SAMPLE_W-1:0] mn, logic signed [SAMPLE_W-1:0] mx);
      if (open_fill[k] == '0) begin
        open_min[k] = mn;
        open_max[k] = mx;
      end else begin
        if (mn < open_min[k]) open_min[k] = mn;
        if (mx > open_max[k]) open_max[k] = mx;
      end
      open_fill[k] = open_fill[k] + 1'b1;
    endfunction

    function void emit(int k);
      bin_t b;
      if (step_bins.size() >= MAX_LEVELS)
        return;
      b.level = LVL_W'(k);
      b.index = emitted[k];
      b.lo    = open_min[k];
      b.hi    = open_max[k];
      b.last  = 1'b0;
      step_bins.insert(step_bins.size(), b);
      emitted[k] = emitted[k] + 1'b1;
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] value, logic chan_end);
      logic signed [SAMPLE_W-1:0] mn;
      logic signed [SAMPLE_W-1:0] mx;
      step_bins.delete();
      samples_seen++;
      mn = value;
      mx = value;
      for (int k = 0; k < MAX_LEVELS; k++) begin
        fold(k, mn, mx);
        if (open_fill[k] < close_count(k))
          break;
        emit(k);
        open_fill[k] = '0;
        mn = open_min[k];
        mx = open_max[k];
      end
      if (chan_end) begin
        // Partial bins move upward until a level that has produced at most one bin.
        for (int k = 0; k < MAX_LEVELS; k++) begin
          if (open_fill[k] != '0) begin
            emit(k);
            open_fill[k] = '0;
            if (k + 1 < MAX_LEVELS)
              fold(k + 1, open_min[k], open_max[k]);
          end
          if (emitted[k] <= 1)
            break;
        end
        clear_levels();
      end
      if (step_bins.size() > 0)
        step_bins[step_bins.size() - 1].last = 1'b1;
      foreach (step_bins[i])
        pending_bins.insert(pending_bins.size(), step_bins[i]);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10)
        $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    function void match_bin(bin_t got);
      bin_t want;
      if (got.level > top_level)
        top_level = got.level;
      if (pending_bins.size() == 0) begin
        flag($sformatf("unexpected bin level %0d index %0d min %0d max %0d last %0b",
                       got.level, got.index, got.lo, got.hi, got.last));
        return;
      end
      want = pending_bins.pop_front();
      bins_checked++;
      if (got.level !== want.level || got.index !== want.index || got.lo !== want.lo ||
          got.hi !== want.hi || got.last !== want.last)
        flag($sformatf({"bin mismatch: expected level %0d index %0d min %0d max %0d ",
                        "last %0b, got level %0d index %0d min %0d max %0d last %0b"},
                       want.level, want.index, want.lo, want.hi, want.last,
                       got.level, got.index, got.lo, got.hi, got.last));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CIDX_W-1:0]   cfg_index;
  logic [CDATA_W-1:0]  cfg_data;

  mmpp_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
  mmpp_out_if #(.SAMPLE_BITS(SAMPLE_W), .BIN_INDEX_BITS(INDEX_W)) out_ch ();

  min_max_peak_pyramid_core #(
    .MAX_LEVELS     (MAX_LEVELS),
    .SAMPLE_BITS    (SAMPLE_W),
    .BIN_INDEX_BITS (INDEX_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pyramid_tracker tracker = new();

  int  cycles   = 0;
  int  channels = 0;
  int  writes   = 0;
  bit  in_steady = 1'b0;

  logic signed [SAMPLE_W-1:0] reset_cfg_vals [6] = '{16'sd32767, -16'sd32768, 16'sd0,
                                                    -16'sd1, 16'sd1, -16'sd32768};
  logic signed [SAMPLE_W-1:0] cascade_vals [12] = '{16'sd100, -16'sd200, 16'sd300,
                                                   -16'sd32768, 16'sd5, 16'sd7,
                                                   16'sd32767, 16'sd0, -16'sd1,
                                                   16'sd12, -16'sd12, 16'sd1};
  logic signed [SAMPLE_W-1:0] clamp_vals [5] = '{-16'sd5, 16'sd32767, -16'sd32768,
                                                16'sd3, 16'sd3};

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return $signed(SAMPLE_W'($urandom_range(0, 6))) - 16'sd3;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic chan_end);
    int gap;
    if ($urandom_range(0, 15) == 0)
      in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.sample_value   <= value;
    in_ch.end_of_channel <= chan_end;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.take_sample(value, chan_end);
  endtask

  task automatic run_channel(input int length, input bit closed);
    for (int i = 0; i < length; i++)
      send_sample(random_sample(), closed && (i == length - 1));
    if (closed)
      channels++;
  endtask

  // Random channels; the last one may stay open into the next setting.
  task automatic random_phase(input int budget);
    int left;
    int length;
    left = budget;
    while (left > 0) begin
      length = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 20);
      if (length > left)
        length = left;
      left -= length;
      run_channel(length, (left > 0) || ($urandom_range(0, 2) != 0));
    end
  endtask

  task automatic configure(input bit set_base, input logic [BASE_W-1:0] base,
                           input bit set_ratio, input logic [RATIO_W-1:0] ratio);
    if (set_base) begin
      cfg_we    <= 1'b1;
      cfg_index <= mmpp_pkg::CFG_IDX_BASE_BIN_FRAMES;
      cfg_data  <= base;
      @(posedge clk);
      tracker.set_reg(mmpp_pkg::CFG_IDX_BASE_BIN_FRAMES, base);
      writes++;
    end
    if (set_ratio) begin
      cfg_we    <= 1'b1;
      cfg_index <= mmpp_pkg::CFG_IDX_LEVEL_RATIO;
      cfg_data  <= {{(CDATA_W - RATIO_W){1'b0}}, ratio};
      @(posedge clk);
      tracker.set_reg(mmpp_pkg::CFG_IDX_LEVEL_RATIO, {{(CDATA_W - RATIO_W){1'b0}}, ratio});
      writes++;
    end
    cfg_we <= 1'b0;
  endtask

  // Waits for every predicted bin, then lets the cascade engine run dry.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.pending_bins.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int   wait_cycles;
    bit   steady;
    bin_t got;
    out_ch.ready = 1'b0;
    steady = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0)
        steady = !steady;
      wait_cycles = steady ? 0 : $urandom_range(0, 10);
      if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.level = out_ch.level_number;
      got.index = out_ch.bin_number;
      got.lo    = out_ch.bin_min;
      got.hi    = out_ch.bin_max;
      got.last  = out_ch.last_of_run;
      tracker.match_bin(got);
    end
  end

  initial begin : stimulus
    bit [1:0] pick;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = mmpp_pkg::CFG_IDX_BASE_BIN_FRAMES;
    cfg_data             = '0;
    in_ch.valid          = 1'b0;
    in_ch.sample_value   = '0;
    in_ch.end_of_channel = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a partial bin holding both extremes, then a one-sample channel.
    foreach (reset_cfg_vals[i])
      send_sample(reset_cfg_vals[i], (i == 4) || (i == 5));
    channels += 2;
    settle();

    // Small bins, ratio two: the channel ends on a level-zero boundary.
    configure(1'b1, 17'd3, 1'b1, 5'd2);
    foreach (cascade_vals[i])
      send_sample(cascade_vals[i], i == 11);
    channels++;
    settle();

    // Zero bin size and ratio below two are clamped to one and two.
    configure(1'b1, 17'd0, 1'b1, 5'd0);
    foreach (clamp_vals[i])
      send_sample(clamp_vals[i], i == 4);
    channels++;
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: configure(1'b1, 17'd1, 1'b1, 5'd16);
        1: configure(1'b1, 17'd65536, 1'b1, 5'd16);
        2: configure(1'b1, 17'd131071, 1'b1, 5'd31);
        3: configure(1'b1, 17'd2, 1'b1, 5'd1);
        4: configure(1'b1, 17'd0, 1'b1, 5'd2);
        default: begin
          pick = 2'($urandom_range(1, 3));
          configure(pick[0], BASE_W'($urandom_range(1, 12)),
                    pick[1], RATIO_W'($urandom_range(2, 6)));
        end
      endcase
      random_phase(30);
      settle();
    end

    // A longer channel with one-sample bins and ratio two climbs several levels.
    configure(1'b1, 17'd1, 1'b1, 5'd2);
    run_channel($urandom_range(50, 70), 1'b1);
    settle();

    $display("Streamed %0d samples in %0d channels over %0d register writes.",
             tracker.samples_seen, channels, writes);
    $display("Checked %0d bins reaching level %0d, %0d failures.",
             tracker.bins_checked, tracker.top_level, tracker.failures);
    if (tracker.failures == 0 && tracker.pending_bins.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/mmpp_pkg.sv
rtl/core/mmpp_intf.sv
rtl/core/mmpp_front.sv
rtl/core/mmpp_queue.sv
rtl/core/mmpp_back.sv
rtl/core/min_max_peak_pyramid_core.sv
verif/tb_min_max_peak_pyramid_core.sv
